// File: hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// File: hdl/ffca_pkg.sv
package ffca_pkg;
    localparam int MaxFreeRuns = 64;
    localparam int AddrW = 64;
    localparam int LenW = 21;
    localparam int StrideW = 13;
    localparam int ProdW = LenW + StrideW;
    localparam logic [LenW-1:0] LenMax = '1;

    // register values after reset
    localparam int StrideReset = 32;
    localparam int UnitsReset = 1024;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StNoFit = 2'd1;
    localparam logic [1:0] StFull = 2'd2;

    localparam logic [1:0] RegBase = 2'd0;
    localparam logic [1:0] RegStride = 2'd1;
    localparam logic [1:0] RegUnits = 2'd2;

    // cell update operations
    localparam logic [1:0] OpKeep = 2'd0;
    localparam logic [1:0] OpLeft = 2'd1;
    localparam logic [1:0] OpRight = 2'd2;
    localparam logic [1:0] OpLoad = 2'd3;

    // per-cell view given to its neighbor
    typedef struct packed {
        logic             valid;
        logic [AddrW-1:0] start;
        logic [LenW-1:0]  len;
        logic [AddrW-1:0] end_addr;
        logic             le_a;     // start <= free address
        logic             fit;      // len >= request
    } t_cell_view;

    // broadcast operands
    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [LenW-1:0]  n;
    } t_bcast;
endpackage

// File: hdl/first_fit_coalescing_allocator.sv
// o_done rises after the span, look and update steps that follow the accepting edge
// a new item is taken only when idle; busy stays high until the update step ends
// a heap_units write rebuilds the row in the same edge
// synchronous reset gives one run (0, 1024) and stride 32
// results appear as a one-cycle strobe on o_done; the receiver cannot stall
module first_fit_coalescing_allocator #(
    parameter int MAX_FREE_RUNS = ffca_pkg::MaxFreeRuns
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [ffca_pkg::AddrW-1:0]    i_cfg_data,
    input  logic                          i_mode,
    input  logic [ffca_pkg::LenW-1:0]     i_unit_count,
    input  logic [ffca_pkg::AddrW-1:0]    i_free_address,
    output logic                          o_done,
    output logic [ffca_pkg::AddrW-1:0]    o_address,
    output logic [1:0]                    o_status
);
    import ffca_pkg::*;
    `include "assert_macros.svh"
    localparam int N = MAX_FREE_RUNS;

    typedef enum logic [3:0] {
        t_idle = 4'b0001, t_span = 4'b0010, t_look = 4'b0100, t_upd = 4'b1000
    } t_state;

    t_state r_state;
    logic [AddrW-1:0] r_base, r_addr, r_nspan, r_aend;
    logic [StrideW-1:0] r_stride;
    logic r_mode;
    logic [LenW-1:0] r_n;
    logic [AddrW-1:0] r_out_addr;
    logic [1:0] r_out_status;
    logic r_done;

    t_cell_view v [N];
    t_bcast bc;
    logic [1:0] op [N];
    logic ld_v [N];
    logic [AddrW-1:0] ld_s [N];
    logic [LenW-1:0] ld_l [N];
    logic wr;

    assign bc.addr = r_addr;
    assign bc.n = r_n;

    // the row of cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        t_cell_view lv, rv;
        if (g == 0) begin : g_l
            assign lv = '0;
        end else begin : g_ln
            assign lv = v[g-1];
        end
        if (g == N-1) begin : g_r
            assign rv = '0;
        end else begin : g_rn
            assign rv = v[g+1];
        end
        ffca_cell u_cell (
            .i_clk, .i_rst_n, .i_first(g == 0), .i_bc(bc), .i_stride(r_stride),
            .i_wr(wr), .i_op(op[g]), .i_left(lv), .i_right(rv),
            .i_load_v(ld_v[g]), .i_load_start(ld_s[g]), .i_load_len(ld_l[g]),
            .o_view(v[g])
        );
    end

    // per-cell decisions: first fit and insert position by prefix chains
    logic fit_here [N];
    logic nx_here [N];
    logic p_here [N];
    logic any_fit, nx_found, full;
    logic [LenW:0] sum_nx, sum_p, sum_both;
    t_cell_view cn, cp;
    logic merge_nx, merge_p, merge_both;
    always_comb begin
        logic fit_seen;
        logic all_le;
        t_cell_view prv;
        fit_seen = 1'b0;
        all_le = 1'b1;
        prv = '0;
        nx_found = 1'b0;
        cn = '0;
        cp = '0;
        for (int i = 0; i < N; i++) begin
            // first valid run long enough
            fit_here[i] = v[i].valid && v[i].fit && !fit_seen;
            fit_seen = fit_seen || (v[i].valid && v[i].fit);
            // first slot whose run does not start at or below the free address
            nx_here[i] = all_le && !(v[i].valid && v[i].le_a);
            all_le = all_le && v[i].valid && v[i].le_a;
            if (nx_here[i]) begin
                nx_found = 1'b1;
                cn = v[i];
                cp = prv;
            end
            prv = v[i];
        end
        any_fit = fit_seen;
        if (!nx_found) cp = v[N-1];
        // slot just below the insert position
        for (int i = 0; i < N-1; i++) p_here[i] = nx_here[i+1];
        p_here[N-1] = !nx_found;
        full = v[N-1].valid;
        sum_nx = {1'b0, cn.len} + {1'b0, r_n};
        sum_p  = {1'b0, cp.len} + {1'b0, r_n};
        sum_both = sum_nx + {1'b0, cp.len};
        merge_nx = cn.valid && r_aend == cn.start && !sum_nx[LenW];
        merge_p  = cp.valid && cp.end_addr == r_addr;
        merge_both = merge_nx && merge_p && !sum_both[LenW];
        merge_p = merge_p && !merge_nx && !sum_p[LenW];
    end

    // cell update commands
    logic [1:0] st;
    logic [AddrW-1:0] oaddr;
    always_comb begin
        logic before_hit;
        before_hit = 1'b0;
        wr = 1'b0;
        st = StOk;
        oaddr = '0;
        for (int i = 0; i < N; i++) begin
            op[i] = OpKeep;
            ld_v[i] = 1'b1;
            ld_s[i] = v[i].start;
            ld_l[i] = v[i].len;
        end
        if (i_cfg_we && i_cfg_index == RegUnits) begin
            wr = 1'b1;
            for (int i = 0; i < N; i++) begin
                op[i] = OpLoad;
                ld_v[i] = (i == 0) && (i_cfg_data[LenW-1:0] != '0);
                ld_s[i] = (i == 0) ? r_base : '0;
                ld_l[i] = (i == 0) ? i_cfg_data[LenW-1:0] : '0;
            end
        end else if (r_state == t_upd && r_n != '0) begin
            if (!r_mode) begin
                if (!any_fit) begin
                    st = StNoFit;
                end else begin
                    wr = 1'b1;
                    for (int i = 0; i < N; i++) begin
                        if (fit_here[i]) begin
                            oaddr = v[i].start;
                            if (v[i].len == r_n) begin
                                before_hit = 1'b1;
                                op[i] = OpRight;
                            end else begin
                                op[i] = OpLoad;
                                ld_s[i] = v[i].start + r_nspan;
                                ld_l[i] = v[i].len - r_n;
                            end
                        end else if (before_hit) begin
                            op[i] = OpRight;
                        end
                    end
                end
            end else if (merge_both) begin
                // lower run absorbs item and upper run, the rest close up
                wr = 1'b1;
                for (int i = 0; i < N; i++) begin
                    if (p_here[i]) begin
                        op[i] = OpLoad;
                        ld_s[i] = cp.start;
                        ld_l[i] = sum_both[LenW-1:0];
                    end else if (nx_here[i] || before_hit) begin
                        before_hit = 1'b1;
                        op[i] = OpRight;
                    end
                end
            end else if (merge_nx) begin
                wr = 1'b1;
                for (int i = 0; i < N; i++) begin
                    if (nx_here[i]) begin
                        op[i] = OpLoad;
                        ld_s[i] = r_addr;
                        ld_l[i] = sum_nx[LenW-1:0];
                    end
                end
            end else if (merge_p) begin
                wr = 1'b1;
                for (int i = 0; i < N; i++) begin
                    if (p_here[i]) begin
                        op[i] = OpLoad;
                        ld_s[i] = cp.start;
                        ld_l[i] = sum_p[LenW-1:0];
                    end
                end
            end else if (full) begin
                st = StFull;
            end else begin
                // lone run: insert and shift the rest up
                wr = 1'b1;
                for (int i = 0; i < N; i++) begin
                    if (nx_here[i]) begin
                        before_hit = 1'b1;
                        op[i] = OpLoad;
                        ld_s[i] = r_addr;
                        ld_l[i] = r_n;
                    end else if (before_hit) begin
                        op[i] = OpLeft;
                    end
                end
            end
        end
    end

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle;
            r_done <= 1'b0;
            r_base <= '0;
            r_stride <= StrideW'(StrideReset);
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we && i_cfg_index == RegBase) r_base <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == RegStride) r_stride <= i_cfg_data[StrideW-1:0];
            unique case (r_state)
                t_idle: if (start) r_state <= t_span;
                t_span: r_state <= t_look;
                t_look: r_state <= t_upd;
                t_upd: begin
                    r_state <= t_idle;
                    r_done <= 1'b1;
                end
                default: r_state <= t_idle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == t_idle && start) begin
            r_mode <= i_mode;
            r_n <= i_unit_count;
            r_addr <= i_free_address;
        end
        if (r_state == t_span) r_nspan <= AddrW'(ProdW'(r_n) * ProdW'(r_stride));
        if (r_state == t_look) r_aend <= r_addr + r_nspan;
        if (r_state == t_upd) begin
            r_out_addr <= (r_mode || r_n == '0) ? '0 : oaddr;
            r_out_status <= (r_n == '0) ? StOk : st;
        end
    end

    assign busy = (r_state != t_idle);
    assign o_done = r_done;
    assign o_address = r_out_addr;
    assign o_status = r_out_status;

    `ASSERT_NXT(a_done_after_upd, i_clk, i_rst_n, r_state == t_upd, o_done)
    `ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, r_state == t_idle)
    `ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_done, o_status != 2'd3)
endmodule

// File: hdl/ffca_cell.sv
// one free-run slot; shifts with neighbors on insert/remove
module ffca_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_first,
    input  ffca_pkg::t_bcast              i_bc,
    input  logic [ffca_pkg::StrideW-1:0]  i_stride,
    input  logic                          i_wr,
    input  logic [1:0]                    i_op,     // keep, from left, from right, load
    input  ffca_pkg::t_cell_view          i_left,
    input  ffca_pkg::t_cell_view          i_right,
    input  logic                          i_load_v,
    input  logic [ffca_pkg::AddrW-1:0]    i_load_start,
    input  logic [ffca_pkg::LenW-1:0]     i_load_len,
    output ffca_pkg::t_cell_view          o_view
);
    import ffca_pkg::*;

    logic             r_valid;
    logic [AddrW-1:0] r_start;
    logic [LenW-1:0]  r_len;
    logic [AddrW-1:0] r_end;

    // end address tracks the contents
    logic [AddrW-1:0] n_end_calc;
    logic             n_valid;
    logic [AddrW-1:0] n_start;
    logic [LenW-1:0]  n_len;

    always_comb begin
        n_valid = r_valid;
        n_start = r_start;
        n_len   = r_len;
        case (i_op)
            OpLeft: begin
                n_valid = i_left.valid;
                n_start = i_left.start;
                n_len   = i_left.len;
            end
            OpRight: begin
                n_valid = i_right.valid;
                n_start = i_right.start;
                n_len   = i_right.len;
            end
            OpLoad: begin
                n_valid = i_load_v;
                n_start = i_load_start;
                n_len   = i_load_len;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= i_first;
            r_start <= '0;
            r_len   <= i_first ? LenW'(UnitsReset) : '0;
        end else if (i_wr) begin
            r_valid <= n_valid;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

    // end = start + len*stride, registered, so it follows the contents in the next cycle
    assign n_end_calc = r_start + AddrW'(ProdW'(r_len) * ProdW'(i_stride));
    always_ff @(posedge i_clk) begin
        r_end <= n_end_calc;
    end

    assign o_view.valid    = r_valid;
    assign o_view.start    = r_start;
    assign o_view.len      = r_len;
    assign o_view.end_addr = r_end;
    assign o_view.le_a     = r_start <= i_bc.addr;
    assign o_view.fit      = r_len >= i_bc.n;
endmodule
